FILE: src/glqr_pkg.sv
// Shared types and constants of the gray-level quantize and remap core.
package glqr_pkg;

   // Width of one gray value and of every configuration register.
   localparam int unsigned PIX_W = 8;

   // Register index port width and the register map.
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUANT_STEPS = 2'd0,
      CSR_RANGE_LOW   = 2'd1,
      CSR_RANGE_HIGH  = 2'd2
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [PIX_W-1:0] QUANT_STEPS_RST = 8'd0;
   localparam logic [PIX_W-1:0] RANGE_LOW_RST   = 8'd0;
   localparam logic [PIX_W-1:0] RANGE_HIGH_RST  = 8'd255;

   // Gray extremes that always pass unchanged.
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

   // Rounded division by 255: floor((x + 127) / 255) is computed as
   // ((x + 127) * 32897) >> 23, which is exact for arguments below 66052.
   localparam int unsigned     PROD_W      = 16;
   localparam int unsigned     WIDE_W      = 32;
   localparam logic [15:0]     HALF_255    = 16'd127;
   localparam logic [15:0]     RECIP_255   = 16'd32897;
   localparam int unsigned     RECIP_SHIFT = 23;

   // Level value divider: numerator 510*q + s, divisor 2*s, quotient 0..255.
   localparam int unsigned     REM_W     = 17;
   localparam logic [REM_W-1:0] LEVEL_SPAN = 17'd510;

   // Pipeline depth: one product stage, one reciprocal stage, one numerator
   // stage, one stage per quotient bit, two remap stages and the output stage.
   localparam int unsigned NUM_STAGES = 6 + PIX_W;

endpackage

FILE: src/gray_level_quantize_remap_core.sv
// Top level of the gray-level quantize and remap core.
// Throughput: one pixel per clock unless rsp_tready stalls the output; the
// quotient of the level divider is formed one bit per stage over eight stages,
// so no unit is shared between pixels.
// A stage takes a new pixel whenever it is empty or its successor moves on.
// Synchronous reset empties the pipeline and loads the register reset values.
module gray_level_quantize_remap_core
   import glqr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input pixel channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIX_W-1:0]     req_tdata,   // [7:0] pixel_in
   // Result pixel channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,   // [7:0] pixel_out
   // Configuration write port.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_wdata
);

   localparam int unsigned LAST     = NUM_STAGES - 1;
   localparam int unsigned ST_PROD  = 0;
   localparam int unsigned ST_RECIP = 1;
   localparam int unsigned ST_NUM   = 2;
   localparam int unsigned ST_DIV0  = 3;
   localparam int unsigned ST_MUL   = ST_DIV0 + PIX_W;
   localparam int unsigned ST_SUM   = ST_MUL + 1;

   // Configuration registers.
   logic [PIX_W-1:0] quant_steps_ff, quant_steps_in;
   logic [PIX_W-1:0] range_low_ff, range_low_in;
   logic [PIX_W-1:0] range_high_ff, range_high_in;

   // Pipeline control.
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   // Pixel and bypass flag travel alongside every stage before the output.
   logic [PIX_W-1:0] c_ff   [LAST];
   logic [PIX_W-1:0] c_in   [LAST];
   logic             byp_ff [LAST];
   logic             byp_in [LAST];

   // Stage payloads.
   logic [PROD_W-1:0] p_ff, p_in;
   logic [WIDE_W-1:0] q_wide;
   logic [PIX_W-1:0]  q_ff, q_in;
   logic [REM_W-1:0]  rem_ff [PIX_W+1];
   logic [REM_W-1:0]  rem_in [PIX_W+1];
   logic [PIX_W-1:0]  quo_ff [PIX_W+1];
   logic [PIX_W-1:0]  quo_in [PIX_W+1];
   logic [REM_W-1:0]  div_den;
   logic [PROD_W-1:0] lo_prod_ff, lo_prod_in;
   logic [PROD_W-1:0] hi_prod_ff, hi_prod_in;
   logic [PROD_W-1:0] sum_ff, sum_in;
   logic [WIDE_W-1:0] res_wide;
   logic [PIX_W-1:0]  pix_out_ff, pix_out_in;
   logic              out_byp_ff, out_byp_in;

   // Configuration writes; an index beyond the map is ignored.
   always_comb begin
      quant_steps_in = quant_steps_ff;
      range_low_in   = range_low_ff;
      range_high_in  = range_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_QUANT_STEPS: quant_steps_in = csr_wdata;
            CSR_RANGE_LOW:   range_low_in   = csr_wdata;
            CSR_RANGE_HIGH:  range_high_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_steps_ff <= QUANT_STEPS_RST;
         range_low_ff   <= RANGE_LOW_RST;
         range_high_ff  <= RANGE_HIGH_RST;
      end else begin
         quant_steps_ff <= quant_steps_in;
         range_low_ff   <= range_low_in;
         range_high_ff  <= range_high_in;
      end
   end

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[0];

   // Pixel and bypass flag carried down the pipeline.
   always_comb begin
      c_in[0]   = adv[0] ? req_tdata : c_ff[0];
      byp_in[0] = adv[0] ? ((quant_steps_ff == '0) || (req_tdata == PIX_BLACK)
                            || (req_tdata == PIX_WHITE)) : byp_ff[0];
      for (int i = 1; i < LAST; i++) begin
         c_in[i]   = adv[i] ? c_ff[i-1]   : c_ff[i];
         byp_in[i] = adv[i] ? byp_ff[i-1] : byp_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LAST; i++) begin
         c_ff[i]   <= c_in[i];
         byp_ff[i] <= byp_in[i];
      end
   end

   // Stage 0: scaled pixel c*s plus half a step.
   assign p_in = adv[ST_PROD]
      ? (PROD_W'(req_tdata) * PROD_W'(quant_steps_ff) + HALF_255) : p_ff;

   // Stage 1: level index q by the reciprocal of 255.
   assign q_wide = WIDE_W'(p_ff) * WIDE_W'(RECIP_255);
   assign q_in   = adv[ST_RECIP] ? q_wide[RECIP_SHIFT +: PIX_W] : q_ff;

   // Stage 2: divider numerator 510*q + s, quotient cleared.
   assign rem_in[0] = adv[ST_NUM]
      ? (REM_W'(q_ff) * LEVEL_SPAN + REM_W'(quant_steps_ff)) : rem_ff[0];
   assign quo_in[0] = adv[ST_NUM] ? '0 : quo_ff[0];

   // Stages 3 to 10: restoring division by 2*s, most significant bit first.
   assign div_den = {{(REM_W-PIX_W-1){1'b0}}, quant_steps_ff, 1'b0};

   for (genvar j = 0; j < PIX_W; j++) begin : g_div
      logic [REM_W-1:0] den_sh;
      logic             take;
      assign den_sh = div_den << (PIX_W - 1 - j);
      assign take   = rem_ff[j] >= den_sh;
      assign rem_in[j+1] = adv[ST_DIV0+j]
         ? (take ? (rem_ff[j] - den_sh) : rem_ff[j]) : rem_ff[j+1];
      assign quo_in[j+1] = adv[ST_DIV0+j]
         ? {quo_ff[j][PIX_W-2:0], take} : quo_ff[j+1];
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
      for (int j = 0; j <= PIX_W; j++) begin
         rem_ff[j] <= rem_in[j];
         quo_ff[j] <= quo_in[j];
      end
   end

   // Stage 11: weights of the two range ends.
   assign lo_prod_in = adv[ST_MUL]
      ? (PROD_W'(range_low_ff) * PROD_W'(PIX_WHITE - quo_ff[PIX_W])) : lo_prod_ff;
   assign hi_prod_in = adv[ST_MUL]
      ? (PROD_W'(range_high_ff) * PROD_W'(quo_ff[PIX_W])) : hi_prod_ff;

   // Stage 12: blended value plus half a step.
   assign sum_in = adv[ST_SUM] ? (lo_prod_ff + hi_prod_ff + HALF_255) : sum_ff;

   // Stage 13: rounded division by 255, or the untouched pixel.
   assign res_wide   = WIDE_W'(sum_ff) * WIDE_W'(RECIP_255);
   assign pix_out_in = adv[LAST]
      ? (byp_ff[LAST-1] ? c_ff[LAST-1] : res_wide[RECIP_SHIFT +: PIX_W]) : pix_out_ff;
   assign out_byp_in = adv[LAST] ? byp_ff[LAST-1] : out_byp_ff;

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      sum_ff     <= sum_in;
      pix_out_ff <= pix_out_in;
      out_byp_ff <= out_byp_in;
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = pix_out_ff;

   // The level index never exceeds the number of steps.
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RECIP] && !byp_ff[ST_RECIP] |-> q_ff <= quant_steps_ff)
      else $error("level index above step count");

   // The divider leaves a remainder below its divisor.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_MUL-1] && !byp_ff[ST_MUL-1] |-> rem_ff[PIX_W] < div_den)
      else $error("divider remainder not below divisor");

   // Input is held off only when the whole pipeline is blocked downstream.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a downstream stall");

   // A remapped pixel lies between the two range ends.
   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_byp_ff |->
         (rsp_tdata >= range_low_ff && rsp_tdata <= range_high_ff) ||
         (rsp_tdata >= range_high_ff && rsp_tdata <= range_low_ff))
      else $error("remapped pixel outside the output range");

endmodule
